// ----- design/goi_pkg.sv -----
// ---------------------------------------------------------------------------
// goi_pkg: shared types and constants for grid obstacle inflation
// Operation codes, register indexes, state encoding and the small
// square-root table used to size each row of the inflation disk.
// ---------------------------------------------------------------------------
package goi_pkg;

  // default sizes of the map and the scan window
  localparam int MaxWidthDef  = 256;
  localparam int MaxHeightDef = 256;
  localparam int MaxRadiusDef = 15;

  // field widths
  localparam int OpW    = 2;
  localparam int CoordW = 8;
  localparam int OccW   = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 9;

  // step counter covers 2 * 15 + 1 rows of the disk
  localparam int StepW = 5;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } goi_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAP_WIDTH     = 3'd0,
    REG_MAP_HEIGHT    = 3'd1,
    REG_THRESHOLD     = 3'd2,
    REG_ALLOW_UNKNOWN = 3'd3,
    REG_RADIUS_LIMIT  = 3'd4,
    REG_REACH_SQUARED = 3'd5
  } goi_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_INFL,
    ST_FLUSH,
    ST_DONE
  } goi_state_e;

  // reset values of the configuration registers
  localparam logic [8:0] MapWidthRst     = 9'd256;
  localparam logic [8:0] MapHeightRst    = 9'd256;
  localparam logic [6:0] ThresholdRst    = 7'd50;
  localparam logic       AllowUnknownRst = 1'b1;
  localparam logic [3:0] RadiusRst       = 4'd5;
  localparam logic [7:0] ReachRst        = 8'd25;

  // floor of the square root of an 8-bit value
  function automatic logic [3:0] isqrt8(input logic [7:0] v);
    logic [3:0] s;
    s = '0;
    for (int i = 1; i < 16; i++) begin
      if (8'(i * i) <= v) begin
        s = 4'(i);
      end
    end
    return s;
  endfunction

endpackage

// ----- design/goi_ram.sv -----
// ---------------------------------------------------------------------------
// goi_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module goi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/grid_obstacle_inflation.sv -----
// ---------------------------------------------------------------------------
// grid_obstacle_inflation: blocked map with disk-shaped obstacle inflation
// Keeps one bit per grid cell in a row-organized memory. Obstacle loads
// mark every row of the disk that lies inside the map with a read-modify-write
// of the whole row; queries read back one bit.
// ---------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i  / in_ready_o  | op_i, cell_x_i, cell_y_i,
//          |           |                           | occupancy_i
//  out     | out       | out_valid_o / out_ready_i | blocked_o, inside_map_o
//
//  one request at a time; the row memory has one read and one write port
//  load of an obstacle: one disk row per cycle, with the read of the next row
//    overlapping the write of the row before it
//  a clear op zeroes the map with a sweep over all rows
//  after reset a sweep over all MAX_HEIGHT rows zeroes the map; in_ready_o stays low,
//    configuration writes are taken throughout
//  a waiting result sits in the output register; the next request is taken
//    meanwhile and its result waits until the register frees up

module grid_obstacle_inflation
  import goi_pkg::*;
#(
  parameter int MAX_WIDTH  = goi_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = goi_pkg::MaxHeightDef,
  parameter int MAX_RADIUS = goi_pkg::MaxRadiusDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [goi_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [goi_pkg::CfgDataW-1:0] cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [goi_pkg::OpW-1:0]      op_i,
  input  logic [goi_pkg::CoordW-1:0]   cell_x_i,
  input  logic [goi_pkg::CoordW-1:0]   cell_y_i,
  input  logic signed [goi_pkg::OccW-1:0] occupancy_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         blocked_o,
  output logic                         inside_map_o
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // configuration registers
  logic [8:0] map_width_q, map_height_q;
  logic [6:0] threshold_q;
  logic       allow_unknown_q;
  logic [3:0] radius_q;
  logic [7:0] reach_q;

  // control
  goi_state_e        state_q, state_d;
  logic [YW-1:0]     clr_q, clr_d;
  logic              clr_op_q, clr_op_d;
  logic [StepW-1:0]  step_q, step_d;
  logic              wv_q, wv_d;
  logic              res_blocked_q, res_blocked_d;
  logic              res_inside_q, res_inside_d;
  logic              out_valid_q, out_valid_d;
  logic              out_blocked_q, out_blocked_d;
  logic              out_inside_q, out_inside_d;

  // payload
  logic [CoordW-1:0] x_q, x_d;
  logic [CoordW-1:0] y_q, y_d;
  logic [YW-1:0]     wrow_q, wrow_d;
  logic [3:0]        wh_q, wh_d;

  // memory port
  logic                 ram_we;
  logic [YW-1:0]        ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata;

  // datapath
  logic [8:0]        eff_w, eff_h;
  logic [3:0]        rad;
  logic              in_map_i;
  logic              obstacle_i;
  logic signed [5:0] dy;
  logic [3:0]        ady;
  logic [7:0]        dy2;
  logic [3:0]        half_w, root;
  logic signed [9:0] row_s;
  logic              row_ok;
  logic [YW-1:0]     row_addr;
  logic              last_step;
  logic [7:0]        span_lo;
  logic [8:0]        span_hi;
  logic [MAX_WIDTH-1:0] row_mask;

  goi_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration port, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_width_q     <= MapWidthRst;
      map_height_q    <= MapHeightRst;
      threshold_q     <= ThresholdRst;
      allow_unknown_q <= AllowUnknownRst;
      radius_q        <= RadiusRst;
      reach_q         <= ReachRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MAP_WIDTH:     map_width_q     <= cfg_data_i;
        REG_MAP_HEIGHT:    map_height_q    <= cfg_data_i;
        REG_THRESHOLD:     threshold_q     <= cfg_data_i[6:0];
        REG_ALLOW_UNKNOWN: allow_unknown_q <= cfg_data_i[0];
        REG_RADIUS_LIMIT:  radius_q        <= cfg_data_i[3:0];
        REG_REACH_SQUARED: reach_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective sizes, saturated to the build limits
  assign eff_w = (int'(map_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : map_width_q;
  assign eff_h = (int'(map_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : map_height_q;
  assign rad   = (int'(radius_q) > MAX_RADIUS) ? 4'(MAX_RADIUS) : radius_q;

  assign in_map_i = ({1'b0, cell_x_i} < eff_w) && ({1'b0, cell_y_i} < eff_h);
  assign obstacle_i = occupancy_i[OccW-1] ? !allow_unknown_q
                                          : (occupancy_i[6:0] >= threshold_q);

  // disk row for the current step: dy = step - r
  assign dy       = $signed({1'b0, step_q}) - $signed({2'b00, rad});
  assign ady      = dy[5] ? 4'(-dy) : dy[3:0];
  assign dy2      = 8'(ady) * 8'(ady);
  assign root     = isqrt8(reach_q - dy2);
  assign half_w   = (root < rad) ? root : rad;
  assign row_s    = $signed({2'b00, y_q}) + $signed({{4{dy[5]}}, dy});
  assign row_ok   = !row_s[9] && (row_s[8:0] < eff_h) && (dy2 <= reach_q);
  assign row_addr = YW'(row_s[8:0]);
  assign last_step = (step_q == {rad, 1'b0});

  // columns covered by the row being written
  assign span_lo = (x_q >= 8'(wh_q)) ? (x_q - 8'(wh_q)) : 8'd0;
  assign span_hi = 9'(x_q) + 9'(wh_q);

  always_comb begin
    for (int j = 0; j < MAX_WIDTH; j++) begin
      row_mask[j] = (j >= int'(span_lo)) && (j <= int'(span_hi)) && (j < int'(eff_w));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      clr_op_q      <= 1'b0;
      step_q        <= '0;
      wv_q          <= 1'b0;
      res_blocked_q <= 1'b0;
      res_inside_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      out_blocked_q <= 1'b0;
      out_inside_q  <= 1'b0;
    end else begin
      state_q       <= state_d;
      clr_q         <= clr_d;
      clr_op_q      <= clr_op_d;
      step_q        <= step_d;
      wv_q          <= wv_d;
      res_blocked_q <= res_blocked_d;
      res_inside_q  <= res_inside_d;
      out_valid_q   <= out_valid_d;
      out_blocked_q <= out_blocked_d;
      out_inside_q  <= out_inside_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    wrow_q <= wrow_d;
    wh_q   <= wh_d;
  end

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    clr_op_d      = clr_op_q;
    step_d        = step_q;
    wv_d          = 1'b0;
    res_blocked_d = res_blocked_q;
    res_inside_d  = res_inside_q;
    out_valid_d   = out_valid_q;
    out_blocked_d = out_blocked_q;
    out_inside_d  = out_inside_q;
    x_d           = x_q;
    y_d           = y_q;
    wrow_d        = wrow_q;
    wh_d          = wh_q;
    in_ready_o    = 1'b0;

    // write stage of the row update, in the cycle after its read
    ram_we    = wv_q;
    ram_waddr = wrow_q;
    ram_wdata = ram_rdata | row_mask;
    ram_raddr = row_addr;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = YW'(clr_q + 1'b1);
        if (clr_q == YW'(MAX_HEIGHT - 1)) begin
          clr_d    = '0;
          clr_op_d = 1'b0;
          if (clr_op_q) begin
            res_blocked_d = 1'b0;
            res_inside_d  = 1'b0;
            state_d       = ST_DONE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        ram_raddr  = YW'(cell_y_i);
        if (in_valid_i) begin
          x_d           = cell_x_i;
          y_d           = cell_y_i;
          res_blocked_d = 1'b0;
          res_inside_d  = 1'b0;
          case (op_i)
            OP_CLEAR: begin
              clr_op_d = 1'b1;
              clr_d    = '0;
              state_d  = ST_CLEAR;
            end
            OP_LOAD: begin
              res_inside_d = in_map_i;
              step_d       = '0;
              state_d      = (in_map_i && obstacle_i) ? ST_INFL : ST_DONE;
            end
            OP_QUERY: begin
              res_inside_d = in_map_i;
              state_d      = in_map_i ? ST_QUERY : ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_QUERY: begin
        res_blocked_d = ram_rdata[XW'(x_q)];
        state_d       = ST_DONE;
      end

      ST_INFL: begin
        // read this row now, merge and write it back next cycle
        wv_d   = row_ok;
        wrow_d = row_addr;
        wh_d   = half_w;
        step_d = StepW'(step_q + 1'b1);
        if (last_step) begin
          state_d = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          out_blocked_d = res_blocked_q;
          out_inside_d  = res_inside_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign blocked_o    = out_blocked_q;
  assign inside_map_o = out_inside_q;

endmodule
